[src/pidsc_pkg.sv]
// Package for the speed PID controller: fixed-point types, constants,
// register indexes and the saturation helper. No dependencies.
package pidsc_pkg;

	localparam int DW = 32;
	localparam int FB = 16;

	typedef logic signed [DW-1:0] fx_t;
	typedef logic [3:0] cfg_idx_t;

	localparam fx_t ONE_FX = fx_t'(1) <<< FB;
	localparam logic [30:0] DT_MIN = 31'd66;

	localparam cfg_idx_t CFG_GAIN_P        = 4'd0;
	localparam cfg_idx_t CFG_GAIN_I        = 4'd1;
	localparam cfg_idx_t CFG_GAIN_D        = 4'd2;
	localparam cfg_idx_t CFG_DRIVE_MIN     = 4'd3;
	localparam cfg_idx_t CFG_DRIVE_MAX     = 4'd4;
	localparam cfg_idx_t CFG_BACKCALC_MODE = 4'd5;
	localparam cfg_idx_t CFG_BACKCALC_GAIN = 4'd6;
	localparam cfg_idx_t CFG_FILTER_TIME   = 4'd7;

	// Saturates a 35-bit signed value to the 32-bit signed range.
	function automatic fx_t sat35(input logic signed [34:0] v);
		fx_t r;
		if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
			r = v[31:0];
		end else if (v[34]) begin
			r = {1'b1, {(DW-1){1'b0}}};
		end else begin
			r = {1'b0, {(DW-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

[src/pidsc_if.sv]
// Channel interfaces of the speed PID controller: step input, drive output
// and configuration write. Depends on nothing.
interface pidsc_step_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [31:0] speed_measured;
	logic signed [31:0] speed_target;
	logic [30:0]        time_step;
	modport source(output valid, kind, speed_measured, speed_target, time_step, input ready);
	modport sink(input valid, kind, speed_measured, speed_target, time_step, output ready);
endinterface

interface pidsc_drive_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] drive_out;
	modport source(output valid, drive_out, input ready);
	modport sink(input valid, drive_out, output ready);
endinterface

interface pidsc_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[src/pidsc_fmul.sv]
// Shared fixed-point multiplier: operand register, product register, then
// rounding to nearest and saturation. Depends on pidsc_pkg.
module pidsc_fmul (
	input  logic                clk,
	input  logic                load,
	input  logic signed [35:0]  a,
	input  logic signed [31:0]  b,
	output pidsc_pkg::fx_t      y
);

	logic [35:0] ma_q;
	logic [31:0] mb_q;
	logic        neg_q;
	logic [67:0] prod_s1;
	logic        neg_s1;
	logic [68:0] rnd;
	logic [52:0] shifted;
	logic [52:0] lim;
	logic [52:0] mag;

	always_ff @(posedge clk) begin
		if (load) begin
			ma_q  <= a[35] ? 36'(-a) : 36'(a);
			mb_q  <= b[31] ? 32'(-b) : 32'(b);
			neg_q <= a[35] ^ b[31];
		end
		prod_s1 <= 68'(ma_q) * 68'(mb_q);
		neg_s1  <= neg_q;
	end

	always_comb begin
		rnd     = 69'(prod_s1) + (69'(1) << (pidsc_pkg::FB - 1));
		shifted = rnd[68:pidsc_pkg::FB];
		lim     = neg_s1 ? (53'(1) << 31) : ((53'(1) << 31) - 53'(1));
		mag     = (shifted > lim) ? lim : shifted;
		y       = neg_s1 ? pidsc_pkg::fx_t'(-mag[31:0]) : pidsc_pkg::fx_t'(mag[31:0]);
	end

endmodule

[src/pidsc_div.sv]
// Shared restoring divider, one quotient bit per cycle, with rounding to
// nearest and saturation of the Q16.16 quotient. Depends on pidsc_pkg.
module pidsc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  pidsc_pkg::fx_t      num,
	input  logic [32:0]         den,
	output logic                busy,
	output logic                done,
	output pidsc_pkg::fx_t      y
);

	localparam int QW = pidsc_pkg::DW + pidsc_pkg::FB;

	logic          busy_q;
	logic          done_q;
	logic [5:0]    cnt_q;
	logic [QW-1:0] nsh_q;
	logic [QW-1:0] quo_q;
	logic [32:0]   rem_q;
	logic [32:0]   den_q;
	logic          neg_q;
	logic [33:0]   rem2;
	logic          fits;
	logic          up;
	logic [QW:0]   qr;
	logic [QW:0]   lim;
	logic [QW:0]   mag;

	assign rem2 = {rem_q, nsh_q[QW-1]};
	assign fits = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(QW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nsh_q <= {(num[31] ? 32'(-num) : 32'(num)), {pidsc_pkg::FB{1'b0}}};
			quo_q <= '0;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[31];
		end else if (busy_q) begin
			nsh_q <= {nsh_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], fits};
			rem_q <= fits ? 33'(rem2 - {1'b0, den_q}) : rem2[32:0];
		end
	end

	always_comb begin
		up  = {rem_q, 1'b0} >= {1'b0, den_q};
		qr  = {1'b0, quo_q} + (QW+1)'(up);
		lim = neg_q ? ((QW+1)'(1) << 31) : (((QW+1)'(1) << 31) - (QW+1)'(1));
		mag = (qr > lim) ? lim : qr;
		y   = neg_q ? pidsc_pkg::fx_t'(-mag[31:0]) : pidsc_pkg::fx_t'(mag[31:0]);
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

[src/pid_speed_controller_antiwindup.sv]
// Top level of the speed PID controller with filtered derivative and
// anti-windup. Depends on pidsc_pkg, pidsc_if, pidsc_fmul and pidsc_div.
// A control step runs two divisions (rate and filter coefficient) on the
// shared divider and up to seven passes through the shared multiplier, in
// sequence; with the filter time at zero the second division is skipped. The
// block takes one step at a time; the next step is accepted once the previous
// result sits in the output register.
module pid_speed_controller_antiwindup (
	input  logic                 clk,
	input  logic                 arst_n,
	pidsc_step_if.sink           step,
	pidsc_drive_if.source        drive,
	pidsc_cfg_if.sink            cfg
);

	typedef enum logic [3:0] {
		S_IDLE, S_DV, S_DV_WAIT, S_AL, S_AL_WAIT, S_MUL, S_MUL_WAIT,
		S_MUL_DONE, S_CLAMP, S_ANTI, S_FIN
	} state_t;

	typedef enum logic [2:0] {
		OP_DF_OLD, OP_DF_NEW, OP_P, OP_I, OP_D, OP_BC, OP_INT
	} op_t;

	state_t state_q;
	op_t    op_q;

	pidsc_pkg::fx_t gain_p_q, gain_i_q, gain_d_q, drive_min_q, drive_max_q, backcalc_gain_q;
	logic           backcalc_mode_q;
	logic [30:0]    filter_time_q;

	pidsc_pkg::fx_t last_q, acc_q, df_q;
	logic           primed_q;

	pidsc_pkg::fx_t     meas_q, e_q, dv_q, alpha_q, t1_q, t2_q, usat_q;
	logic [30:0]        dt_q;
	logic signed [33:0] uraw_q;
	logic signed [35:0] diff_q;
	logic signed [35:0] ea_q;
	logic               out_valid_q;
	pidsc_pkg::fx_t     out_data_q;

	logic               div_start, div_busy, div_done;
	pidsc_pkg::fx_t     div_num, div_y;
	logic [32:0]        div_den;
	logic               mul_load;
	logic signed [35:0] mul_a;
	logic signed [31:0] mul_b;
	pidsc_pkg::fx_t     mul_y;
	pidsc_pkg::fx_t     lim_lo, lim_hi;
	logic               at_hi, at_lo;

	pidsc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .done(div_done), .y(div_y)
	);

	pidsc_fmul u_fmul (.clk(clk), .load(mul_load), .a(mul_a), .b(mul_b), .y(mul_y));

	assign step.ready  = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;
	assign drive.valid = out_valid_q;
	assign drive.drive_out = out_data_q;

	assign div_start = (state_q == S_DV) || (state_q == S_AL);
	assign mul_load  = (state_q == S_MUL);

	always_comb begin
		if (state_q == S_AL) begin
			div_num = pidsc_pkg::fx_t'({1'b0, filter_time_q});
			div_den = 33'(filter_time_q) + 33'(dt_q);
		end else begin
			div_num = pidsc_pkg::sat35(35'(meas_q) - 35'(last_q));
			div_den = 33'(dt_q);
		end
	end

	always_comb begin
		unique case (op_q)
			OP_DF_OLD: begin mul_a = 36'(alpha_q); mul_b = df_q; end
			OP_DF_NEW: begin mul_a = 36'(pidsc_pkg::ONE_FX - alpha_q); mul_b = dv_q; end
			OP_P:      begin mul_a = 36'(e_q); mul_b = gain_p_q; end
			OP_I:      begin mul_a = 36'(acc_q); mul_b = gain_i_q; end
			OP_D:      begin mul_a = 36'(df_q); mul_b = gain_d_q; end
			OP_BC:     begin mul_a = diff_q; mul_b = backcalc_gain_q; end
			OP_INT:    begin mul_a = ea_q; mul_b = pidsc_pkg::fx_t'({1'b0, dt_q}); end
			default:   begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		if (drive_max_q < drive_min_q) begin
			lim_lo = drive_max_q;
			lim_hi = drive_min_q;
		end else begin
			lim_lo = drive_min_q;
			lim_hi = drive_max_q;
		end
		at_hi = (uraw_q >= 34'(lim_hi)) && !e_q[31] && (e_q != '0);
		at_lo = (uraw_q <= 34'(lim_lo)) && e_q[31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q        <= pidsc_pkg::ONE_FX;
			gain_i_q        <= '0;
			gain_d_q        <= '0;
			drive_min_q     <= '0;
			drive_max_q     <= 32'sd16711680;
			backcalc_mode_q <= 1'b0;
			backcalc_gain_q <= '0;
			filter_time_q   <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				pidsc_pkg::CFG_GAIN_P:        gain_p_q        <= cfg.data;
				pidsc_pkg::CFG_GAIN_I:        gain_i_q        <= cfg.data;
				pidsc_pkg::CFG_GAIN_D:        gain_d_q        <= cfg.data;
				pidsc_pkg::CFG_DRIVE_MIN:     drive_min_q     <= cfg.data;
				pidsc_pkg::CFG_DRIVE_MAX:     drive_max_q     <= cfg.data;
				pidsc_pkg::CFG_BACKCALC_MODE: backcalc_mode_q <= cfg.data[0];
				pidsc_pkg::CFG_BACKCALC_GAIN: backcalc_gain_q <= cfg.data;
				pidsc_pkg::CFG_FILTER_TIME:   filter_time_q   <= cfg.data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_DF_OLD;
			out_valid_q <= 1'b0;
			primed_q    <= 1'b0;
			last_q      <= '0;
			acc_q       <= '0;
			df_q        <= '0;
		end else begin
			if (drive.ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (step.valid) begin
						if (step.kind) begin
							primed_q <= 1'b0;
							last_q   <= '0;
							acc_q    <= '0;
							df_q     <= '0;
							meas_q   <= '0;
							usat_q   <= '0;
							state_q  <= S_FIN;
						end else begin
							meas_q <= step.speed_measured;
							e_q    <= pidsc_pkg::sat35(35'(step.speed_target)
								- 35'(step.speed_measured));
							dt_q   <= (step.time_step == '0) ? pidsc_pkg::DT_MIN : step.time_step;
							if (!primed_q) begin
								last_q   <= step.speed_measured;
								df_q     <= '0;
								primed_q <= 1'b1;
							end
							state_q <= S_DV;
						end
					end
				end
				S_DV: state_q <= S_DV_WAIT;
				S_DV_WAIT: begin
					if (div_done) begin
						dv_q <= div_y;
						if (filter_time_q != '0) begin
							state_q <= S_AL;
						end else begin
							alpha_q <= '0;
							op_q    <= OP_DF_OLD;
							state_q <= S_MUL;
						end
					end
				end
				S_AL: state_q <= S_AL_WAIT;
				S_AL_WAIT: begin
					if (div_done) begin
						alpha_q <= div_y;
						op_q    <= OP_DF_OLD;
						state_q <= S_MUL;
					end
				end
				S_MUL:      state_q <= S_MUL_WAIT;
				S_MUL_WAIT: state_q <= S_MUL_DONE;
				S_MUL_DONE: begin
					state_q <= S_MUL;
					unique case (op_q)
						OP_DF_OLD: begin
							t1_q <= mul_y;
							op_q <= OP_DF_NEW;
						end
						OP_DF_NEW: begin
							df_q <= pidsc_pkg::sat35(35'(t1_q) + 35'(mul_y));
							op_q <= OP_P;
						end
						OP_P: begin
							t1_q <= mul_y;
							op_q <= OP_I;
						end
						OP_I: begin
							t2_q <= mul_y;
							op_q <= OP_D;
						end
						OP_D: begin
							uraw_q <= 34'(t1_q) + 34'(t2_q)
								+ 34'(pidsc_pkg::sat35(-35'(mul_y)));
							state_q <= S_CLAMP;
						end
						OP_BC: begin
							ea_q <= 36'(e_q) + 36'(mul_y);
							op_q <= OP_INT;
						end
						OP_INT: begin
							acc_q   <= pidsc_pkg::sat35(35'(acc_q) + 35'(mul_y));
							state_q <= S_FIN;
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_CLAMP: begin
					if (uraw_q > 34'(lim_hi)) begin
						usat_q <= lim_hi;
					end else if (uraw_q < 34'(lim_lo)) begin
						usat_q <= lim_lo;
					end else begin
						usat_q <= uraw_q[31:0];
					end
					state_q <= S_ANTI;
				end
				S_ANTI: begin
					if (backcalc_mode_q) begin
						diff_q  <= 36'(usat_q) - 36'(uraw_q);
						op_q    <= OP_BC;
						state_q <= S_MUL;
					end else if (!(at_hi || at_lo)) begin
						ea_q    <= 36'(e_q);
						op_q    <= OP_INT;
						state_q <= S_MUL;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || drive.ready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= usat_q;
						last_q      <= meas_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_ready_not_div: assert property (@(posedge clk) disable iff (!arst_n)
		step.ready |-> !div_busy)
		else $error("step accepted while the divider is busy");

	a_clear_unprimes: assert property (@(posedge clk) disable iff (!arst_n)
		(step.valid && step.ready && step.kind) |=> (!primed_q && acc_q == '0))
		else $error("clear transaction did not reset the controller state");

	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DV_WAIT || state_q == S_AL_WAIT))
		else $error("divider finished outside a wait state");

endmodule
